@@ rtl/lpm_pkg.sv @@
package lpm_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 8;
  localparam int GROUP_W    = 6;
  localparam int AMOUNT_W   = 14;
  localparam int IDX_W      = $clog2(MAX_ITEMS);
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W      = VALUE_BITS + $clog2(MAX_ITEMS);
  localparam int DIFF_W     = CNT_W + 1;

  localparam logic KIND_SUM  = 1'b0;
  localparam logic KIND_SIZE = 1'b1;

  typedef struct packed {
    logic clear;
    logic step;
  } fit_ctrl_t;

endpackage

@@ rtl/lpm_ifs.sv @@
interface lpm_in_if;
  logic                            valid;
  logic                            ready;
  logic [lpm_pkg::VALUE_BITS-1:0] value;
  logic                            last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink (input valid, input value, input last_item, output ready);
endinterface

interface lpm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [lpm_pkg::AMOUNT_W-1:0] amount;
  logic                          last_result;

  modport source (output valid, output kind, output amount, output last_result, input ready);
  modport sink (input valid, input kind, input amount, input last_result, output ready);
endinterface

interface lpm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lpm_pkg::GROUP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/lpm_store.sv @@
module lpm_store (
  input  logic                            clk,
  input  logic                            we,
  input  logic [lpm_pkg::IDX_W-1:0]      waddr,
  input  logic [lpm_pkg::VALUE_BITS-1:0] wdata,
  input  logic [lpm_pkg::IDX_W-1:0]      raddr,
  output logic [lpm_pkg::VALUE_BITS-1:0] rdata
);

  logic [lpm_pkg::VALUE_BITS-1:0] mem [lpm_pkg::MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lpm_fit_unit.sv @@
module lpm_fit_unit (
  input  logic                            clk,
  input  lpm_pkg::fit_ctrl_t              ctrl,
  input  logic [lpm_pkg::VALUE_BITS-1:0] value,
  input  logic [lpm_pkg::SUM_W-1:0]      limit,
  output logic                            fits
);

  logic [lpm_pkg::SUM_W-1:0] acc;
  logic [lpm_pkg::SUM_W:0]   total;

  assign total = {1'b0, acc} + (lpm_pkg::SUM_W + 1)'(value);
  assign fits  = total <= {1'b0, limit};

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.step) begin
      acc <= fits ? total[lpm_pkg::SUM_W-1:0] : lpm_pkg::SUM_W'(value);
    end
  end

endmodule

@@ rtl/linear_partition_min_max_sum.sv @@
// Linear partition of a loaded sequence into a fixed number of contiguous
// groups with the smallest possible largest group sum.
// The items channel takes one value per beat; the beat with last_item set
// closes the sequence and starts the run. The channel is ready throughout
// loading. The cfg channel writes group_count and is always ready; write it
// only while the block is idle.
// After the last beat the block binary searches the answer. Each probe is a
// greedy pass through the value store, one stored value per cycle through a
// shared add and compare unit. The results channel then carries the minimal
// maximum sum (kind 0) and one group size per beat (kind 1), the final beat
// flagged by last_result. The size pass walks one stored value per cycle and
// sends a size as each group closes; the trailing groups of one go out one
// per cycle. A stalled receiver holds the output register and pauses the
// size pass. Items are not accepted during the search and emission.
// Reset clears the item count, running sum and largest value and sets
// group_count to one; no clearing pass.
module linear_partition_min_max_sum (
  input  logic       clk,
  input  logic       rst,
  lpm_in_if.sink     items,
  lpm_cfg_if.sink    cfg,
  lpm_out_if.source  results
);

  typedef enum logic [8:0] {
    S_LOAD   = 9'b000000001,
    S_INIT   = 9'b000000010,
    S_MID    = 9'b000000100,
    S_PASS   = 9'b000001000,
    S_DECIDE = 9'b000010000,
    S_SUM    = 9'b000100000,
    S_EMIT   = 9'b001000000,
    S_ONES   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [lpm_pkg::CNT_W-1:0]      item_total, item_total_next;
  logic [lpm_pkg::SUM_W-1:0]      running_sum, running_sum_next;
  logic [lpm_pkg::VALUE_BITS-1:0] largest_value, largest_value_next;
  logic [lpm_pkg::GROUP_W-1:0]    group_count;
  logic [lpm_pkg::CNT_W-1:0]      groups, groups_next;
  logic [lpm_pkg::SUM_W-1:0]      lo, lo_next, hi, hi_next, mid, mid_next;
  logic [lpm_pkg::IDX_W-1:0]      idx, idx_next;
  logic [lpm_pkg::CNT_W-1:0]      gcount, gcount_next;
  logic [lpm_pkg::CNT_W-1:0]      count, count_next;
  logic [lpm_pkg::CNT_W-1:0]      emitted, emitted_next;

  logic                           out_valid;
  logic                           out_kind;
  logic [lpm_pkg::AMOUNT_W-1:0]   out_amount;
  logic                           out_last;

  logic                           emit;
  logic                           e_kind;
  logic [lpm_pkg::AMOUNT_W-1:0]   e_amount;
  logic                           e_last;

  logic                           load_beat;
  logic                           store_we;
  logic [lpm_pkg::VALUE_BITS-1:0] rdata;
  logic                           fits;
  lpm_pkg::fit_ctrl_t             fit_ctrl;
  logic [lpm_pkg::SUM_W-1:0]      limit;
  logic                           can_emit;
  logic                           at_end;
  logic [lpm_pkg::CNT_W-1:0]      left_items;
  logic [lpm_pkg::DIFF_W-1:0]     left_groups;
  logic [lpm_pkg::CNT_W-1:0]      clamped;
  logic [lpm_pkg::SUM_W:0]        lo_hi_sum;

  assign items.ready = (state == S_LOAD);
  assign cfg.ready   = 1'b1;
  assign load_beat   = items.valid && items.ready;
  assign store_we    = load_beat && (item_total < lpm_pkg::CNT_W'(lpm_pkg::MAX_ITEMS));
  assign can_emit    = !out_valid || results.ready;
  assign at_end      = (lpm_pkg::CNT_W'(idx) == item_total - 1'b1);
  assign left_items  = item_total - lpm_pkg::CNT_W'(idx);
  assign left_groups = {1'b0, groups} - {1'b0, emitted};
  assign limit       = (state == S_PASS) ? mid : lo;
  assign lo_hi_sum   = {1'b0, lo} + {1'b0, hi};
  assign clamped     = (group_count == '0) ? lpm_pkg::CNT_W'(1)
                                           : lpm_pkg::CNT_W'(group_count);

  lpm_store u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (item_total[lpm_pkg::IDX_W-1:0]),
    .wdata (items.value),
    .raddr (idx_next),
    .rdata (rdata)
  );

  lpm_fit_unit u_fit (
    .clk   (clk),
    .ctrl  (fit_ctrl),
    .value (rdata),
    .limit (limit),
    .fits  (fits)
  );

  always_comb begin
    state_next         = state;
    item_total_next    = item_total;
    running_sum_next   = running_sum;
    largest_value_next = largest_value;
    groups_next        = groups;
    lo_next            = lo;
    hi_next            = hi;
    mid_next           = mid;
    idx_next           = idx;
    gcount_next        = gcount;
    count_next         = count;
    emitted_next       = emitted;
    fit_ctrl           = '0;
    emit               = 1'b0;
    e_kind             = lpm_pkg::KIND_SIZE;
    e_amount           = '0;
    e_last             = 1'b0;

    case (state)
      S_LOAD: begin
        idx_next = '0;
        if (store_we) begin
          item_total_next  = item_total + 1'b1;
          running_sum_next = running_sum + lpm_pkg::SUM_W'(items.value);
          if (items.value > largest_value) begin
            largest_value_next = items.value;
          end
        end
        if (load_beat && items.last_item) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        groups_next = (clamped > item_total) ? item_total : clamped;
        lo_next     = lpm_pkg::SUM_W'(largest_value);
        hi_next     = running_sum;
        state_next  = S_MID;
      end
      S_MID: begin
        if (lo <= hi) begin
          mid_next       = lo_hi_sum[lpm_pkg::SUM_W:1];
          idx_next       = '0;
          gcount_next    = lpm_pkg::CNT_W'(1);
          fit_ctrl.clear = 1'b1;
          state_next     = S_PASS;
        end else begin
          state_next = S_SUM;
        end
      end
      S_PASS: begin
        fit_ctrl.step = 1'b1;
        if (!fits) begin
          gcount_next = gcount + 1'b1;
        end
        if (at_end) begin
          state_next = S_DECIDE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_DECIDE: begin
        if (gcount <= groups) begin
          if (mid == '0) begin
            state_next = S_SUM;
          end else begin
            hi_next    = mid - 1'b1;
            state_next = S_MID;
          end
        end else begin
          lo_next    = mid + 1'b1;
          state_next = S_MID;
        end
      end
      S_SUM: begin
        if (can_emit) begin
          emit           = 1'b1;
          e_kind         = lpm_pkg::KIND_SUM;
          e_amount       = lpm_pkg::AMOUNT_W'(lo);
          fit_ctrl.clear = 1'b1;
          idx_next       = '0;
          count_next     = '0;
          emitted_next   = '0;
          state_next     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          fit_ctrl.step = 1'b1;
          if (fits) begin
            count_next = count + 1'b1;
            if ({1'b0, left_items} == left_groups) begin
              emit     = 1'b1;
              e_amount = lpm_pkg::AMOUNT_W'(count + 1'b1);
              e_last   = (left_items == lpm_pkg::CNT_W'(1));
              if (at_end) begin
                state_next = S_DONE;
              end else begin
                idx_next   = idx + 1'b1;
                state_next = S_ONES;
              end
            end else if (at_end) begin
              state_next = S_DONE;
            end else begin
              idx_next = idx + 1'b1;
            end
          end else begin
            emit         = 1'b1;
            e_amount     = lpm_pkg::AMOUNT_W'(count);
            emitted_next = emitted + 1'b1;
            count_next   = lpm_pkg::CNT_W'(1);
            if ({1'b0, left_items} == left_groups - 1'b1) begin
              state_next = S_ONES;
            end else if (at_end) begin
              state_next = S_DONE;
            end else begin
              idx_next = idx + 1'b1;
            end
          end
        end
      end
      S_ONES: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_amount = lpm_pkg::AMOUNT_W'(1);
          e_last   = at_end;
          if (at_end) begin
            state_next = S_DONE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      S_DONE: begin
        item_total_next    = '0;
        running_sum_next   = '0;
        largest_value_next = '0;
        idx_next           = '0;
        state_next         = S_LOAD;
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      item_total    <= '0;
      running_sum   <= '0;
      largest_value <= '0;
      group_count   <= lpm_pkg::GROUP_W'(1);
      idx           <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      item_total    <= item_total_next;
      running_sum   <= running_sum_next;
      largest_value <= largest_value_next;
      idx           <= idx_next;
      if (cfg.valid && cfg.ready) begin
        group_count <= cfg.data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    groups  <= groups_next;
    lo      <= lo_next;
    hi      <= hi_next;
    mid     <= mid_next;
    gcount  <= gcount_next;
    count   <= count_next;
    emitted <= emitted_next;
    if (emit) begin
      out_kind   <= e_kind;
      out_amount <= e_amount;
      out_last   <= e_last;
    end
  end

  assign results.valid       = out_valid;
  assign results.kind        = out_kind;
  assign results.amount      = out_amount;
  assign results.last_result = out_last;

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> (item_total == '0) && (running_sum == '0))
    else $error("counters not cleared after a run");

  a_pass_groups: assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS) |-> ({1'b0, gcount} <= ({1'b0, lpm_pkg::CNT_W'(idx)} + 1'b1)))
    else $error("greedy pass needs more groups than items seen");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_MID) |-> ({1'b0, lo} <= ({1'b0, hi} + 1'b1)))
    else $error("binary search bounds crossed by more than one");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS || state == S_EMIT || state == S_ONES) |-> !store_we)
    else $error("store written while the run is in progress");

endmodule
